FILE: hdl/rlsd_pkg.sv
// ----------------------------------------------------------------------------
// rlsd_pkg: shared types and constants for the LED panel scan driver
// Field widths, mode codes, reset values and the column item carried from
// the sequencer to the output compare stage.
// ----------------------------------------------------------------------------
package rlsd_pkg;

	// default sizes
	localparam int COLUMNS_DEF     = 64;
	localparam int PIXEL_COUNT_DEF = 256;

	// field widths
	localparam int PIX_W     = 6;
	localparam int CHAN_W    = 2;
	localparam int PHASE_W   = 3;
	localparam int ROW_W     = 2;
	localparam int ROWSEL_W  = 3;
	localparam int MODE_W    = 2;
	localparam int INDEX_W   = 8;
	localparam int IN_DATA_W = 16;
	localparam int OUT_DATA_W = 16;

	// input item kinds
	localparam logic [MODE_W-1:0] MODE_WRITE   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REFRESH = 2'd2;

	// reset and coding constants
	localparam logic [PHASE_W-1:0]  PHASE_TOP_RST = 3'd4;
	localparam logic [ROWSEL_W-1:0] ROWSEL_BASE   = 3'd7;

	// one column in flight between sequencer and output stage
	typedef struct packed {
		logic                valid;
		logic                last;
		logic [PHASE_W-1:0]  phase;
		logic [ROWSEL_W-1:0] row_sel;
	} rlsd_col_t;

	// channel lit when strictly above the brightness phase
	function automatic logic chan_lit(input logic [CHAN_W-1:0] chan,
			input logic [PHASE_W-1:0] phase);
		return ({1'b0, chan} > phase);
	endfunction

endpackage

FILE: hdl/rlsd_ram.sv
// ----------------------------------------------------------------------------
// rlsd_ram: generic RAM, one write port, two registered read ports
// Read data registers load only when the read enable is high and hold
// otherwise.
// ----------------------------------------------------------------------------
module rlsd_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

FILE: hdl/rlsd_seq.sv
// ----------------------------------------------------------------------------
// rlsd_seq: command sequencer
// Takes input items, writes or clears the pixel store, advances phase and
// scan row on a refresh, issues one column read pair per cycle unless stalled.
// ----------------------------------------------------------------------------
module rlsd_seq #(
	parameter int COLUMNS     = rlsd_pkg::COLUMNS_DEF,
	parameter int PIXEL_COUNT = rlsd_pkg::PIXEL_COUNT_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// command items
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [rlsd_pkg::MODE_W-1:0]          mode,
	input  logic [rlsd_pkg::INDEX_W-1:0]         pixel_index,
	input  logic [rlsd_pkg::PIX_W-1:0]           pixel_color,
	// phase_top register
	input  logic                                 cfg_we,
	input  logic [rlsd_pkg::PHASE_W-1:0]         cfg_wdata,
	// column handoff
	input  logic                                 adv,
	output rlsd_pkg::rlsd_col_t                  col,
	// pixel store
	output logic                                 ram_we,
	output logic [$clog2(PIXEL_COUNT)-1:0]       ram_waddr,
	output logic [rlsd_pkg::PIX_W-1:0]           ram_wdata,
	output logic                                 ram_re,
	output logic [$clog2(PIXEL_COUNT)-1:0]       ram_raddr_u,
	output logic [$clog2(PIXEL_COUNT)-1:0]       ram_raddr_l
);
	import rlsd_pkg::*;

	localparam int AW = $clog2(PIXEL_COUNT);
	localparam int CW = $clog2(COLUMNS);
	localparam logic [AW-1:0] ADDR_LAST = AW'(PIXEL_COUNT - 1);
	localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
	// first read addresses for the low and high row pairs
	localparam logic [AW-1:0] UP_LO_START = '0;
	localparam logic [AW-1:0] UP_HI_START = AW'(COLUMNS % PIXEL_COUNT);
	localparam logic [AW-1:0] LO_LO_START = AW'((PIXEL_COUNT / 2) % PIXEL_COUNT);
	localparam logic [AW-1:0] LO_HI_START =
		AW'((COLUMNS + PIXEL_COUNT / 2) % PIXEL_COUNT);

	// states
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CLEAR = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;

	logic [1:0]         state_q;
	logic [AW-1:0]      clr_q;
	logic [AW-1:0]      up_addr_q;
	logic [AW-1:0]      lo_addr_q;
	logic [CW-1:0]      col_q;
	logic [PHASE_W-1:0] phase_q;
	logic [PHASE_W-1:0] phase_top_q;
	logic [ROW_W-1:0]   row_q;
	logic               s1_valid_q;
	logic               s1_last_q;

	logic               accept;
	logic               issue;
	logic               idx_ok;
	logic [ROW_W-1:0]   row_next;

	assign in_ready = (state_q == ST_IDLE) && !s1_valid_q;
	assign accept   = in_valid && in_ready;
	assign issue    = (state_q == ST_SCAN) && (!s1_valid_q || adv);
	assign idx_ok   = (32'(pixel_index) < 32'(PIXEL_COUNT));
	assign row_next = row_q + 1'b1;

	// store write port: clearing pass or single pixel write
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		if (state_q == ST_CLEAR) begin
			ram_we = 1'b1;
		end else if (accept && (mode == MODE_WRITE) && idx_ok) begin
			ram_we    = 1'b1;
			ram_waddr = AW'(pixel_index);
			ram_wdata = pixel_color;
		end
	end

	assign ram_re      = issue;
	assign ram_raddr_u = up_addr_q;
	assign ram_raddr_l = lo_addr_q;

	// column in the read stage
	assign col.valid   = s1_valid_q;
	assign col.last    = s1_last_q;
	assign col.phase   = phase_q;
	assign col.row_sel = ROWSEL_BASE - {1'b0, row_q};

	// phase_top register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_top_q <= PHASE_TOP_RST;
		end else if (cfg_we) begin
			phase_top_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			up_addr_q  <= '0;
			lo_addr_q  <= '0;
			col_q      <= '0;
			phase_q    <= '0;
			row_q      <= '0;
			s1_valid_q <= 1'b0;
			s1_last_q  <= 1'b0;
		end else begin
			// read stage occupancy
			if (issue) begin
				s1_valid_q <= 1'b1;
				s1_last_q  <= (col_q == COL_LAST);
			end else if (adv) begin
				s1_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept && (mode == MODE_CLEAR)) begin
						clr_q   <= '0;
						state_q <= ST_CLEAR;
					end else if (accept && (mode == MODE_REFRESH)) begin
						phase_q   <= (phase_q >= phase_top_q) ? '0 : phase_q + 1'b1;
						row_q     <= row_next;
						up_addr_q <= row_next[1] ? UP_HI_START : UP_LO_START;
						lo_addr_q <= row_next[1] ? LO_HI_START : LO_LO_START;
						col_q     <= '0;
						state_q   <= ST_SCAN;
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						up_addr_q <= (up_addr_q == ADDR_LAST) ? '0 : up_addr_q + 1'b1;
						lo_addr_q <= (lo_addr_q == ADDR_LAST) ? '0 : lo_addr_q + 1'b1;
						col_q     <= col_q + 1'b1;
						if (col_q == COL_LAST) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: hdl/rlsd_shade.sv
// ----------------------------------------------------------------------------
// rlsd_shade: brightness compare unit and output register
// Compares the six color channels of a column pair against the phase and
// holds the result item until the sink takes it.
// ----------------------------------------------------------------------------
module rlsd_shade (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rlsd_pkg::rlsd_col_t                 col,
	input  logic [rlsd_pkg::PIX_W-1:0]          px_upper,
	input  logic [rlsd_pkg::PIX_W-1:0]          px_lower,
	output logic                                adv,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [rlsd_pkg::OUT_DATA_W-1:0]     m_tdata,
	output logic                                m_tlast
);
	import rlsd_pkg::*;

	logic                out_valid_q;
	logic [5:0]          bits_q;
	logic [ROWSEL_W-1:0] row_sel_q;
	logic                last_q;
	logic [5:0]          bits_d;

	assign adv = col.valid && (!out_valid_q || m_tready);

	// red, green, blue of upper then lower half
	assign bits_d = {
		chan_lit(px_lower[1:0], col.phase),
		chan_lit(px_lower[3:2], col.phase),
		chan_lit(px_lower[5:4], col.phase),
		chan_lit(px_upper[1:0], col.phase),
		chan_lit(px_upper[3:2], col.phase),
		chan_lit(px_upper[5:4], col.phase)
	};

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (adv) begin
			bits_q    <= bits_d;
			row_sel_q <= col.row_sel;
			last_q    <= col.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_DATA_W - 9)'(0), row_sel_q, bits_q};
	assign m_tlast  = last_q;

endmodule

FILE: hdl/rgb_led_panel_scan_driver_unit.sv
// ----------------------------------------------------------------------------
// rgb_led_panel_scan_driver_unit: RGB LED panel scan driver
// Pixel store of six-bit pixels with per-pixel write and full clear; a
// refresh item advances the brightness phase and scan row and streams one
// column item per column with upper and lower half color bits.
// ----------------------------------------------------------------------------
//  channel   dir  tdata (low bit up)                          tuser / tlast
//  s_axis    in   pixel_index[7:0], pixel_color[13:8]         tuser[1:0] mode
//  m_axis    out  r/g/b upper [2:0], r/g/b lower [5:3],       tlast last_column
//                 row_select [8:6]
//  cfg       in   cfg_wdata = phase_top, written on cfg_we
//
//  Write item: written on accept. Clear item: every store entry, one a cycle.
//  Refresh item: one column a cycle while m_axis does not stall, through the dual
//  read port of the pixel store into its read register, then the output register.
//  After reset a clearing pass of the store runs before s_axis_tready rises.
//  m_axis stalls back up to the store read; s_axis_tready stays low while a
//  refresh is being read out, and rises again while the last column waits.
// ----------------------------------------------------------------------------
module rgb_led_panel_scan_driver_unit #(
	parameter int COLUMNS     = rlsd_pkg::COLUMNS_DEF,
	parameter int PIXEL_COUNT = rlsd_pkg::PIXEL_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// pixel_index [7:0], pixel_color [13:8], zero fill
	input  logic [rlsd_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// mode [1:0]
	input  logic [rlsd_pkg::MODE_W-1:0]       s_axis_tuser,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// red_upper, green_upper, blue_upper, red_lower, green_lower, blue_lower,
	// row_select [8:6], zero fill
	output logic [rlsd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	output logic                              m_axis_tlast,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	input  logic                              cfg_we,
	input  logic [rlsd_pkg::PHASE_W-1:0]      cfg_wdata
);
	import rlsd_pkg::*;

	localparam int AW = $clog2(PIXEL_COUNT);

	rlsd_col_t          col;
	logic               adv;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [PIX_W-1:0]   ram_wdata;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr_u;
	logic [AW-1:0]      ram_raddr_l;
	logic [PIX_W-1:0]   px_upper;
	logic [PIX_W-1:0]   px_lower;

	rlsd_seq #(
		.COLUMNS     (COLUMNS),
		.PIXEL_COUNT (PIXEL_COUNT)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.mode        (s_axis_tuser),
		.pixel_index (s_axis_tdata[7:0]),
		.pixel_color (s_axis_tdata[13:8]),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.adv         (adv),
		.col         (col),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_re      (ram_re),
		.ram_raddr_u (ram_raddr_u),
		.ram_raddr_l (ram_raddr_l)
	);

	rlsd_ram #(
		.WIDTH (PIX_W),
		.DEPTH (PIXEL_COUNT)
	) u_store (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.re      (ram_re),
		.raddr_a (ram_raddr_u),
		.raddr_b (ram_raddr_l),
		.rdata_a (px_upper),
		.rdata_b (px_lower)
	);

	rlsd_shade u_shade (
		.clk      (clk),
		.arst_n   (arst_n),
		.col      (col),
		.px_upper (px_upper),
		.px_lower (px_lower),
		.adv      (adv),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.m_tdata  (m_axis_tdata),
		.m_tlast  (m_axis_tlast)
	);

endmodule

FILE: hdl/rlsd_checker.sv
// ----------------------------------------------------------------------------
// rlsd_checker: port-level checks for the LED panel scan driver
// Watches the stream ports and flags stalls that drop items, broken column
// runs and bad row select coding.
// ----------------------------------------------------------------------------
module rlsd_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tready,
	input logic [rlsd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input logic                              m_axis_tlast,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready
);

	// a stalled result item stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result item dropped under stall");

	// row select is always one of the four row codes, padding is zero
	a_row_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[8] && (m_axis_tdata[15:9] == 7'd0))
		else $error("bad row select or padding");

	// mid-run the input side stays closed
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("input open before last column");

	// columns of one run follow back to back on the same row
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast
		|=> m_axis_tvalid && $stable(m_axis_tdata[8:6]))
		else $error("column run broken");

endmodule

bind rgb_led_panel_scan_driver_unit rlsd_checker u_rlsd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready)
);

FILE: tb/rlsd_scan_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rlsd_scan_checker: column stream checker for the LED panel scan driver
// Watches the pixel, column and config channels, keeps its own pixel store,
// brightness phase and scan row, predicts every column item of a refresh and
// compares each delivered column against the oldest prediction.
// ----------------------------------------------------------------------------
module rlsd_scan_checker #(
	parameter int COLUMNS     = rlsd_pkg::COLUMNS_DEF,
	parameter int PIXEL_COUNT = rlsd_pkg::PIXEL_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [rlsd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input  logic [rlsd_pkg::MODE_W-1:0]     s_axis_tuser,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic [rlsd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                            m_axis_tlast,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic                            cfg_we,
	input  logic [rlsd_pkg::PHASE_W-1:0]    cfg_wdata,
	output int                              fail_count,
	output int                              expected_left
);
	import rlsd_pkg::*;

	localparam int AW = $clog2(PIXEL_COUNT);

	// one predicted column
	typedef struct packed {
		logic                r_up;
		logic                g_up;
		logic                b_up;
		logic                r_lo;
		logic                g_lo;
		logic                b_lo;
		logic [ROWSEL_W-1:0] row_sel;
		logic                last;
	} column_t;

	logic [PIX_W-1:0]   pixels [PIXEL_COUNT];
	logic [PHASE_W-1:0] phase_now;
	logic [ROW_W-1:0]   row_now;
	logic [PHASE_W-1:0] phase_limit;
	column_t            column_q[$];

	// channel at bit offset sh lit when strictly above the phase
	function automatic logic chan_above(input logic [PIX_W-1:0] px, input int sh,
			input logic [PHASE_W-1:0] ph);
		logic [CHAN_W-1:0] ch;
		ch = px[sh +: CHAN_W];
		return ({1'b0, ch} > ph);
	endfunction

	// advance phase and row, then queue one column per panel column
	task automatic predict_refresh();
		int      upper_base;
		int      lower_base;
		column_t col;
		logic [PIX_W-1:0] pu;
		logic [PIX_W-1:0] pl;
		logic [AW-1:0]    ua;
		logic [AW-1:0]    la;
		if (phase_now >= phase_limit) begin
			phase_now = '0;
		end else begin
			phase_now = phase_now + 1'b1;
		end
		row_now = row_now + 1'b1;
		upper_base = (row_now >= 2) ? COLUMNS : 0;
		lower_base = upper_base + PIXEL_COUNT / 2;
		for (int c = 0; c < COLUMNS; c++) begin
			ua = AW'((upper_base + c) % PIXEL_COUNT);
			la = AW'((lower_base + c) % PIXEL_COUNT);
			pu = pixels[ua];
			pl = pixels[la];
			col.r_up    = chan_above(pu, 4, phase_now);
			col.g_up    = chan_above(pu, 2, phase_now);
			col.b_up    = chan_above(pu, 0, phase_now);
			col.r_lo    = chan_above(pl, 4, phase_now);
			col.g_lo    = chan_above(pl, 2, phase_now);
			col.b_lo    = chan_above(pl, 0, phase_now);
			col.row_sel = ROWSEL_BASE - {1'b0, row_now};
			col.last    = (c == COLUMNS - 1);
			column_q.push_back(col);
		end
	endtask

	task automatic check_field(input string fname, input int want, input int got);
		if (want != got) begin
			$display("t=%0t %s mismatch: expected %0d actual %0d", $time, fname, want, got);
			fail_count++;
		end
	endtask

	// pops before pushes: a column can never belong to an item taken this edge
	always @(posedge clk or negedge arst_n) begin
		column_t want;
		if (!arst_n) begin
			foreach (pixels[i]) pixels[i] = '0;
			phase_now     = '0;
			row_now       = '0;
			phase_limit   = PHASE_TOP_RST;
			column_q.delete();
			fail_count    = 0;
			expected_left <= 0;
		end else begin
			if (cfg_we) begin
				phase_limit = cfg_wdata;
			end
			// compare delivered column
			if (m_axis_tvalid && m_axis_tready) begin
				if (column_q.size() == 0) begin
					$display("t=%0t column item with nothing expected: data %h last %b",
						$time, m_axis_tdata, m_axis_tlast);
					fail_count++;
				end else begin
					want = column_q.pop_front();
					check_field("red_upper",   int'(want.r_up),    int'(m_axis_tdata[0]));
					check_field("green_upper", int'(want.g_up),    int'(m_axis_tdata[1]));
					check_field("blue_upper",  int'(want.b_up),    int'(m_axis_tdata[2]));
					check_field("red_lower",   int'(want.r_lo),    int'(m_axis_tdata[3]));
					check_field("green_lower", int'(want.g_lo),    int'(m_axis_tdata[4]));
					check_field("blue_lower",  int'(want.b_lo),    int'(m_axis_tdata[5]));
					check_field("row_select",  int'(want.row_sel), int'(m_axis_tdata[8:6]));
					check_field("last_column", int'(want.last),    int'(m_axis_tlast));
				end
			end
			// apply accepted pixel item
			if (s_axis_tvalid && s_axis_tready) begin
				case (s_axis_tuser)
					MODE_WRITE: begin
						if (int'(s_axis_tdata[7:0]) < PIXEL_COUNT)
							pixels[AW'(s_axis_tdata[7:0])] = s_axis_tdata[13:8];
					end
					MODE_CLEAR: begin
						foreach (pixels[i]) pixels[i] = '0;
					end
					MODE_REFRESH: begin
						predict_refresh();
					end
					default: ;
				endcase
			end
			expected_left <= column_q.size();
		end
	end

endmodule

FILE: tb/tb_rgb_led_panel_scan_driver_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb_led_panel_scan_driver_unit: testbench for the LED panel scan driver
// Directed pixel writes, clears and refreshes around the store and phase
// corners, then random item mixes under several phase_top settings with
// random gaps on the pixel side and random stalls on the column side.
// ----------------------------------------------------------------------------
module tb_rgb_led_panel_scan_driver_unit;
	import rlsd_pkg::*;

	localparam int COLUMNS     = COLUMNS_DEF;
	localparam int PIXEL_COUNT = PIXEL_COUNT_DEF;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int PHASES      = 5;
	localparam int PHASE_ITEMS = 54;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [MODE_W-1:0]     s_axis_tuser = MODE_WRITE;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [PHASE_W-1:0]    cfg_wdata = '0;

	int  fail_count;
	int  expected_left;
	int  cycles = 0;
	int  stall_left = 0;
	int  stall_window = 0;
	bit  rx_burst = 1'b0;
	bit  tx_burst = 1'b0;

	always #5 clk = ~clk;

	rgb_led_panel_scan_driver_unit #(
		.COLUMNS     (COLUMNS),
		.PIXEL_COUNT (PIXEL_COUNT)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	rlsd_scan_checker #(
		.COLUMNS     (COLUMNS),
		.PIXEL_COUNT (PIXEL_COUNT)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.fail_count    (fail_count),
		.expected_left (expected_left)
	);

	// mostly no gap, some short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 20);
	endfunction

	// column sink: random stalls, with stall-free windows now and then
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (stall_window == 0) begin
				stall_window = 200;
				rx_burst = ($urandom_range(0, 3) == 0);
			end else begin
				stall_window--;
			end
			if (stall_left != 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
				if (!rx_burst && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// one pixel item; tvalid stays high into the next item when no gap is drawn
	task automatic send_item(input logic [MODE_W-1:0] mode, input logic [INDEX_W-1:0] idx,
			input logic [PIX_W-1:0] color);
		int gap;
		gap = tx_burst ? 0 : pick_gap();
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata  <= {2'b00, color, idx};
		s_axis_tuser  <= mode;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// hold off until every column is out and a clear could have finished
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_left != 0) @(posedge clk);
		repeat (PIXEL_COUNT + 2 * COLUMNS) @(posedge clk);
	endtask

	task automatic write_phase_top(input logic [PHASE_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		int sent;
		int r;
		logic [PHASE_W-1:0] top_val;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// store corners and the half boundaries of each data source
		send_item(MODE_WRITE, 8'd0,   6'h3F);
		send_item(MODE_WRITE, 8'd63,  6'h30);
		send_item(MODE_WRITE, 8'd128, 6'h0C);
		send_item(MODE_WRITE, 8'd191, 6'h03);
		send_item(MODE_WRITE, 8'd64,  6'h15);
		send_item(MODE_WRITE, 8'd127, 6'h2A);
		send_item(MODE_WRITE, 8'd192, 6'h3F);
		send_item(MODE_WRITE, 8'd255, 6'h3F);
		// phase walks up to 3 under the reset top, rows 1..3
		send_item(MODE_REFRESH, 8'd0, 6'h00);
		send_item(MODE_REFRESH, 8'hFF, 6'h3F);
		send_item(MODE_REFRESH, 8'h5A, 6'h25);
		// top dropped below the live phase: next tick wraps to zero
		wait_idle();
		write_phase_top(3'd1);
		send_item(MODE_REFRESH, 8'hA5, 6'h1A);
		send_item(MODE_REFRESH, 8'd0, 6'h00);
		send_item(MODE_REFRESH, 8'd0, 6'h00);
		// unused mode is ignored, clear keeps phase and row
		send_item(MODE_UNUSED, 8'hFF, 6'h3F);
		send_item(MODE_CLEAR, 8'd0, 6'h00);
		send_item(MODE_REFRESH, 8'd0, 6'h00);
		send_item(MODE_WRITE, 8'd1, 6'h3F);
		send_item(MODE_WRITE, 8'd255, 6'h00);
		send_item(MODE_REFRESH, 8'd0, 6'h00);

		// random mixes, one phase_top setting per phase
		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			if (p == 0) top_val = 3'd7;
			else if (p == 2) top_val = 3'd1;
			else top_val = PHASE_W'($urandom_range(1, 7));
			write_phase_top(top_val);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if (sent % 16 == 0)
					tx_burst = ($urandom_range(0, 3) == 0);
				r = $urandom_range(0, 99);
				if (r < 48) begin
					send_item(MODE_WRITE, INDEX_W'($urandom_range(0, 255)),
						PIX_W'($urandom_range(0, 63)));
					sent++;
				end else if (r < 88) begin
					send_item(MODE_REFRESH, INDEX_W'($urandom_range(0, 255)),
						PIX_W'($urandom_range(0, 63)));
					sent++;
				end else if (r < 94) begin
					send_item(MODE_CLEAR, INDEX_W'($urandom_range(0, 255)),
						PIX_W'($urandom_range(0, 63)));
					sent++;
				end else begin
					send_item(MODE_UNUSED, INDEX_W'($urandom_range(0, 255)),
						PIX_W'($urandom_range(0, 63)));
				end
			end
		end

		wait_idle();
		if (fail_count == 0 && expected_left == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
